// ===== sv/sobel_edge_magnitude_rgb_macros.svh =====
// Assertion macros shared by the checker of the Sobel edge block.
// No dependencies; included by the checker file only.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SEM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sobel edge check failed");

// Next-cycle implication, disabled during reset.
`define SEM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sobel edge check failed");

`endif

// ===== sv/sem_pkg.sv =====
// Shared constants and controller/datapath interface types of the Sobel edge block.
// No dependencies.
`default_nettype none
package sem_pkg;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4095;
	localparam int PIX_W          = 8;
	localparam int FW_W           = 11;
	localparam int FH_W           = 12;
	localparam int CFG_DATA_W     = 12;
	localparam int CFG_IDX_W      = 1;
	localparam int GRAD_W         = 11;
	localparam int SQ_W           = 21;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
	localparam logic [FH_W-1:0] FH_RESET = 12'd1;

	localparam logic [SQ_W-1:0]  ROOT_LIMIT = 21'd65280;
	localparam logic [PIX_W-1:0] EDGE_MAX   = 8'd255;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic read;
		logic update;
		logic grad;
		logic root_start;
		logic load_out;
	} sem_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic emit;
		logic root_busy;
		logic out_free;
	} sem_status_t;
endpackage
`default_nettype wire

// ===== sv/sobel_edge_magnitude_rgb.sv =====
// An item without a result passes the read and update states; an item with a result then goes
// through the gradient, start and root states (the 8 steps of the square-root units) and is
// loaded into the output register once that is free. One item at a time: no new item until it is done.
// Reset clears counters, control and configuration (width 1024, height 1); the row stores
// are not cleared, since every stale entry falls under the frame-edge masks.
`default_nettype none
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [sem_pkg::PIX_W-1:0]       in_red,
	input  wire logic [sem_pkg::PIX_W-1:0]       in_green,
	input  wire logic [sem_pkg::PIX_W-1:0]       in_blue,
	input  wire logic                            drain,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [sem_pkg::PIX_W-1:0]            edge_red,
	output logic [sem_pkg::PIX_W-1:0]            edge_green,
	output logic [sem_pkg::PIX_W-1:0]            edge_blue,
	output logic                                 frame_end
);
	sem_pkg::sem_cmd_t    cmd;
	sem_pkg::sem_status_t status;

	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sem_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.drain      (drain),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.edge_red   (edge_red),
		.edge_green (edge_green),
		.edge_blue  (edge_blue),
		.frame_end  (frame_end)
	);
endmodule
`default_nettype wire

// ===== sv/sem_root.sv =====
// Iterative rounded square root of gx*gx + gy*gy for one channel, one bit per cycle.
// Depends on sem_pkg.
`default_nettype none
module sem_root (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [sem_pkg::GRAD_W-1:0]   gx,
	input  wire logic signed [sem_pkg::GRAD_W-1:0]   gy,
	output logic                                     busy,
	output logic             [sem_pkg::PIX_W-1:0]    root
);
	logic [sem_pkg::SQ_W-1:0]  sq_q;
	logic [sem_pkg::PIX_W-1:0] n_q;
	logic [sem_pkg::PIX_W-1:0] b_q;
	logic                      busy_q;
	logic signed [2*sem_pkg::GRAD_W-1:0] gx2;
	logic signed [2*sem_pkg::GRAD_W-1:0] gy2;
	logic [sem_pkg::PIX_W-1:0]   t;
	logic [2*sem_pkg::PIX_W-1:0] prod;

	// Squares of the gradients and the trial product of the current bit.
	always_comb begin
		gx2  = gx * gx;
		gy2  = gy * gy;
		t    = n_q | b_q;
		prod = 16'(t) * 16'(t - 8'd1);
	end

	// Keep the largest n with n*(n-1) below the sum of squares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q == 8'd1) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sq_q <= sem_pkg::SQ_W'(gx2) + sem_pkg::SQ_W'(gy2);
			n_q  <= '0;
			b_q  <= 8'h80;
		end else if (busy_q) begin
			if ({5'd0, prod} < sq_q) begin
				n_q <= t;
			end
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign root = (sq_q > sem_pkg::ROOT_LIMIT) ? sem_pkg::EDGE_MAX : n_q;
endmodule
`default_nettype wire

// ===== sv/sem_datapath.sv =====
// Datapath: configuration, position counters, two row stores, 3x3 window, gradients,
// square-root units and the output register. Depends on sem_pkg and sem_root.
`default_nettype none
module sem_datapath #(
	parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire sem_pkg::sem_cmd_t                   cmd,
	output sem_pkg::sem_status_t                     status,
	input  wire logic                                cfg_wen,
	input  wire logic [sem_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sem_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic [sem_pkg::PIX_W-1:0]           in_red,
	input  wire logic [sem_pkg::PIX_W-1:0]           in_green,
	input  wire logic [sem_pkg::PIX_W-1:0]           in_blue,
	input  wire logic                                drain,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [sem_pkg::PIX_W-1:0]                edge_red,
	output logic [sem_pkg::PIX_W-1:0]                edge_green,
	output logic [sem_pkg::PIX_W-1:0]                edge_blue,
	output logic                                     frame_end
);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int RW  = $clog2(MAX_HEIGHT + 2);
	localparam int EWW = (WW > sem_pkg::FW_W) ? WW : sem_pkg::FW_W;
	localparam int EHW = (HW > sem_pkg::FH_W) ? HW : sem_pkg::FH_W;
	localparam int PXW = 3 * sem_pkg::PIX_W;
	localparam int GW  = sem_pkg::GRAD_W;

	logic [sem_pkg::FW_W-1:0] fw_q;
	logic [sem_pkg::FH_W-1:0] fh_q;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [EWW-1:0] fw_x;
	logic [EHW-1:0] fh_x;

	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [CW-1:0] in_col_n, out_col_n;
	logic [RW-1:0] in_row_n, out_row_n;

	logic [PXW-1:0] pix_q;
	logic           drain_q;
	logic [PXW-1:0] older_s1, newer_s1;
	logic [PXW-1:0] store_older [MAX_WIDTH];
	logic [PXW-1:0] store_newer [MAX_WIDTH];
	logic [PXW-1:0] taps_q [9];
	logic [PXW-1:0] v;

	logic [3:0] ok_q;
	logic       last_q;
	logic       emit;
	logic       last;
	logic [8:0] ok;

	logic signed [GW-1:0] gx_q [3];
	logic signed [GW-1:0] gy_q [3];
	logic [2:0]            busy;
	logic [sem_pkg::PIX_W-1:0] root [3];
	logic                  out_valid_q;
	logic [sem_pkg::PIX_W-1:0] red_q, green_q, blue_q;
	logic                  frame_end_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= sem_pkg::FW_RESET;
			fh_q <= sem_pkg::FH_RESET;
		end else if (cfg_wen) begin
			if (cfg_index == sem_pkg::REG_FRAME_WIDTH) begin
				fw_q <= cfg_data[sem_pkg::FW_W-1:0];
			end else if (cfg_index == sem_pkg::REG_FRAME_HEIGHT) begin
				fh_q <= cfg_data[sem_pkg::FH_W-1:0];
			end
		end
	end

	// Width and height clamped to the supported range.
	always_comb begin
		fw_x = EWW'(fw_q);
		fh_x = EHW'(fh_q);
		if (fw_x == '0) begin
			w_eff = WW'(1);
		end else if (fw_x > EWW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fw_x);
		end
		if (fh_x == '0) begin
			h_eff = HW'(1);
		end else if (fh_x > EHW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(fh_x);
		end
	end

	// Column counters at or past the width wrap to the next row.
	always_comb begin
		if (WW'(in_col_q) >= w_eff) begin
			in_col_n = '0;
			in_row_n = in_row_q + RW'(1);
		end else begin
			in_col_n = in_col_q;
			in_row_n = in_row_q;
		end
		if (WW'(out_col_q) >= w_eff) begin
			out_col_n = '0;
			out_row_n = out_row_q + RW'(1);
		end else begin
			out_col_n = out_col_q;
			out_row_n = out_row_q;
		end
	end

	// Pixel entering the stores, result condition and frame end.
	always_comb begin
		v    = (drain_q || in_row_q >= RW'(h_eff)) ? '0 : pix_q;
		emit = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
		last = (out_row_q + RW'(1) >= RW'(h_eff)) &&
			(WW'(out_col_q) + WW'(1) >= w_eff);
	end

	// Position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cmd.read) begin
			in_col_q  <= in_col_n;
			in_row_q  <= in_row_n;
			out_col_q <= out_col_n;
			out_row_q <= out_row_n;
		end else if (cmd.update) begin
			if (emit && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (WW'(in_col_q) + WW'(1) >= w_eff) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (emit) begin
					if (WW'(out_col_q) + WW'(1) >= w_eff) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + RW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// Input item register.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			pix_q   <= {in_red, in_green, in_blue};
			drain_q <= drain;
		end
	end

	// Row stores: read in one cycle, written back in the next.
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			older_s1 <= store_older[in_col_n];
			newer_s1 <= store_newer[in_col_n];
		end
		if (cmd.update) begin
			store_older[in_col_q] <= newer_s1;
			store_newer[in_col_q] <= v;
		end
	end

	// Window shift and edge masks of the result position.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			taps_q[0] <= taps_q[1];
			taps_q[1] <= taps_q[2];
			taps_q[2] <= older_s1;
			taps_q[3] <= taps_q[4];
			taps_q[4] <= taps_q[5];
			taps_q[5] <= newer_s1;
			taps_q[6] <= taps_q[7];
			taps_q[7] <= taps_q[8];
			taps_q[8] <= v;
			ok_q[0] <= out_row_q != '0;
			ok_q[1] <= out_row_q + RW'(1) < RW'(h_eff);
			ok_q[2] <= out_col_q != '0;
			ok_q[3] <= WW'(out_col_q) + WW'(1) < w_eff;
			last_q  <= last;
		end
	end

	// Tap masks: top row, middle row, bottom row crossed with the columns.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				ok[r * 3 + c] = (r != 0 || ok_q[0]) && (r != 2 || ok_q[1]) &&
					(c != 0 || ok_q[2]) && (c != 2 || ok_q[3]);
			end
		end
	end

	// Sobel gradients per channel, then the square-root units.
	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		logic signed [GW-1:0] m [9];
		logic signed [GW-1:0] gx, gy;

		always_comb begin
			for (int k = 0; k < 9; k++) begin
				m[k] = ok[k] ?
					$signed({3'd0, taps_q[k][PXW-1-8*ch -: sem_pkg::PIX_W]}) : '0;
			end
			gx = (m[2] - m[0]) + ((m[5] - m[3]) <<< 1) + (m[8] - m[6]);
			gy = (m[6] + (m[7] <<< 1) + m[8]) - (m[0] + (m[1] <<< 1) + m[2]);
		end

		always_ff @(posedge clk) begin
			if (cmd.grad) begin
				gx_q[ch] <= gx;
				gy_q[ch] <= gy;
			end
		end

		sem_root u_root (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (cmd.root_start),
			.gx     (gx_q[ch]),
			.gy     (gy_q[ch]),
			.busy   (busy[ch]),
			.root   (root[ch])
		);
	end

	// Output register: holds a result item until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			red_q       <= root[0];
			green_q     <= root[1];
			blue_q      <= root[2];
			frame_end_q <= last_q;
		end
	end

	always_comb begin
		status.emit      = emit;
		status.root_busy = |busy;
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign edge_red   = red_q;
	assign edge_green = green_q;
	assign edge_blue  = blue_q;
	assign frame_end  = frame_end_q;
endmodule
`default_nettype wire

// ===== sv/sem_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
// Depends on sem_pkg.
`default_nettype none
module sem_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire sem_pkg::sem_status_t  status,
	output sem_pkg::sem_cmd_t          cmd
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_READ   = 3'd1;
	localparam logic [2:0] S_UPDATE = 3'd2;
	localparam logic [2:0] S_GRAD   = 3'd3;
	localparam logic [2:0] S_START  = 3'd4;
	localparam logic [2:0] S_ROOT   = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_n;

	// Next state and commands.
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.latch = in_valid;
				if (in_valid) begin
					state_n = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_n  = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_n    = status.emit ? S_GRAD : S_IDLE;
			end
			S_GRAD: begin
				cmd.grad = 1'b1;
				state_n  = S_START;
			end
			S_START: begin
				cmd.root_start = 1'b1;
				state_n        = S_ROOT;
			end
			S_ROOT: begin
				if (!status.root_busy) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_ready = (state_q == S_IDLE);
endmodule
`default_nettype wire

// ===== sv/sem_checker.sv =====
// Port-level checker of the Sobel edge block, bound to the top level.
// Depends on the assertion macros header.
`default_nettype none
`include "sobel_edge_magnitude_rgb_macros.svh"
module sem_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] edge_red,
	input wire logic [7:0] edge_green,
	input wire logic [7:0] edge_blue,
	input wire logic       frame_end
);
	// A stalled result stays offered.
	`SEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// A stalled result keeps its payload.
	`SEM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(edge_red) && $stable(edge_green) && $stable(edge_blue) && $stable(frame_end))
	// One item at a time: an accepted item closes the input for a while.
	`SEM_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
	// A new result only appears while the input is busy with its item.
	`SEM_ASSERT_NOW(a_result_busy, $rose(out_valid), !$past(in_ready))
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.edge_red   (edge_red),
	.edge_green (edge_green),
	.edge_blue  (edge_blue),
	.frame_end  (frame_end)
);
`default_nettype wire
